FILE: design/binned_vector_stats_2d_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 2D binned vector statistics block.
// Each macro clocks on clk; the plain form is disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BINNED_VECTOR_STATS_2D_ASSERT_SVH
`define BINNED_VECTOR_STATS_2D_ASSERT_SVH
`ifndef SYNTHESIS
`define BVS_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  prop) else $error("bvs assertion failed");
`define BVS_ASSERT_RST(lbl, prop) lbl: assert property (@(posedge clk) prop) \
  else $error("bvs reset assertion failed");
`else
`define BVS_ASSERT(lbl, prop)
`define BVS_ASSERT_RST(lbl, prop)
`endif
`endif

FILE: design/bvs_pkg.sv
// ----------------------------------------------------------------------------
// bvs_pkg
// Shared constants, command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bvs_pkg;

  localparam int GRID_W_DEF = 32;
  localparam int GRID_H_DEF = 32;
  localparam int DIM_DEF    = 8;

  // Field widths.
  localparam int CW = 16;
  localparam int VW = 18;
  localparam int SW = 40;
  localparam int NW = 32;

  // Command codes.
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_RECT  = 2'd2;
  localparam logic [1:0] FUNC_DISC  = 2'd3;

  // Value range limits and bin reset contents.
  localparam logic signed [VW-1:0] V_MAX   = 18'sd131071;
  localparam logic signed [VW-1:0] V_MIN   = -18'sd131072;
  localparam logic signed [VW-1:0] V_ONE   = 18'sd65536;
  localparam logic signed [SW-1:0] S_MAX   = 40'sd549755813887;
  localparam logic signed [SW-1:0] S_MIN   = -40'sd549755813888;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic setup;
    logic add_rd;
    logic add_wr;
    logic walk_init;
    logic walk_rd;
    logic walk_sq;
    logic walk_acc;
    logic div_start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       clr_done;
    logic       empty;
    logic       walk_last;
    logic       cnt_zero;
    logic       div_done;
    logic       dim_last;
  } status_t;

endpackage

FILE: design/binned_vector_stats_2d.sv
// ----------------------------------------------------------------------------
// binned_vector_stats_2d
// 2D histogram of GRID_W x GRID_H bins with per-bin vector statistics.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken when start is high and busy is low. in_func picks
//   clear, add element, rectangle query or disc query.
//   An add element runs capture, bin setup, memory read and write in turn.
//   A clear sweeps every element entry once, 2^(XW+YW+JW) entries, with
//   XW, YW, JW the address widths of x, y and element index. The same sweep
//   runs after reset, with busy high.
//   A query gives DIM result beats. Per element it walks the bin box from
//   bin (0,0) up to its upper corner, reading, squaring and accumulating each
//   bin. When the count is nonzero it then starts the serial divider for the
//   average (40 quotient bits), and strobes out_valid for one cycle. The bin
//   walk and divider set the time.
//   Results cannot be held off by the receiver; each beat is valid for
//   exactly one cycle and out_last marks the final one.
// ----------------------------------------------------------------------------
module binned_vector_stats_2d #(
  parameter int GRID_W = bvs_pkg::GRID_W_DEF,
  parameter int GRID_H = bvs_pkg::GRID_H_DEF,
  parameter int DIM    = bvs_pkg::DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_func,
  input  logic signed [bvs_pkg::CW-1:0]    in_coord_x,
  input  logic signed [bvs_pkg::CW-1:0]    in_coord_y,
  input  logic signed [bvs_pkg::CW-1:0]    in_coord_x2,
  input  logic signed [bvs_pkg::CW-1:0]    in_coord_y2,
  input  logic signed [bvs_pkg::CW-1:0]    in_radius,
  input  logic signed [bvs_pkg::VW-1:0]    in_value,
  output logic                             out_valid,
  output logic [5:0]                       out_dim_index,
  output logic [bvs_pkg::NW-1:0]           out_total_count,
  output logic signed [bvs_pkg::SW-1:0]    out_elem_sum,
  output logic signed [bvs_pkg::VW-1:0]    out_elem_min,
  output logic signed [bvs_pkg::VW-1:0]    out_elem_max,
  output logic signed [bvs_pkg::VW-1:0]    out_elem_avg,
  output logic                             out_zero_count,
  output logic                             out_last
);
  import bvs_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // Sequencer.
  bvs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // Datapath with the bin memories.
  bvs_dp #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H),
    .DIM    (DIM)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_func),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_coord_x2     (in_coord_x2),
    .in_coord_y2     (in_coord_y2),
    .in_radius       (in_radius),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_dim_index   (out_dim_index),
    .out_total_count (out_total_count),
    .out_elem_sum    (out_elem_sum),
    .out_elem_min    (out_elem_min),
    .out_elem_max    (out_elem_max),
    .out_elem_avg    (out_elem_avg),
    .out_zero_count  (out_zero_count),
    .out_last        (out_last)
  );

endmodule

FILE: design/bvs_div.sv
// ----------------------------------------------------------------------------
// bvs_div
// Restoring unsigned divider, one quotient bit per cycle, for the average.
// ----------------------------------------------------------------------------
module bvs_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bvs_pkg::SW-1:0]      dividend,
  input  logic [bvs_pkg::NW-1:0]      divisor,
  output logic [bvs_pkg::SW-1:0]      quotient,
  output logic                        done
);
  import bvs_pkg::*;

  logic [NW-1:0] rem_r;
  logic [SW-1:0] quo_r;
  logic [NW-1:0] dvs_r;
  logic [5:0]    cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [NW:0]   trial;
  logic          fits;

  // Shift in the next dividend bit and try the subtraction.
  assign trial = {rem_r, quo_r[SW-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  // Iteration control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(SW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? NW'(trial - {1'b0, dvs_r}) : trial[NW-1:0];
      quo_r <= {quo_r[SW-2:0], fits};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

FILE: design/bvs_ctrl.sv
// ----------------------------------------------------------------------------
// bvs_ctrl
// Sequencer for clear sweeps, element adds and region query walks.
// ----------------------------------------------------------------------------
module bvs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output bvs_pkg::cmd_t    cmd,
  input  bvs_pkg::status_t sts
);
  import bvs_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLEAR  = 4'd1;
  localparam logic [3:0] S_SETUP  = 4'd2;
  localparam logic [3:0] S_ADD_RD = 4'd3;
  localparam logic [3:0] S_ADD_WR = 4'd4;
  localparam logic [3:0] S_Q_INIT = 4'd5;
  localparam logic [3:0] S_Q_RD   = 4'd6;
  localparam logic [3:0] S_Q_SQ   = 4'd7;
  localparam logic [3:0] S_Q_ACC  = 4'd8;
  localparam logic [3:0] S_Q_FIN  = 4'd9;
  localparam logic [3:0] S_Q_DIV  = 4'd10;
  localparam logic [3:0] S_Q_EMIT = 4'd11;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // State register; reset starts with a clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        case (sts.func)
          FUNC_CLEAR: state_nxt = S_CLEAR;
          FUNC_ADD:   state_nxt = S_ADD_RD;
          default:    state_nxt = S_Q_INIT;
        endcase
      end
      S_ADD_RD: begin
        cmd.add_rd = 1'b1;
        state_nxt  = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_Q_INIT: begin
        cmd.walk_init = 1'b1;
        state_nxt     = sts.empty ? S_Q_FIN : S_Q_RD;
      end
      S_Q_RD: begin
        cmd.walk_rd = 1'b1;
        state_nxt   = S_Q_SQ;
      end
      S_Q_SQ: begin
        cmd.walk_sq = 1'b1;
        state_nxt   = S_Q_ACC;
      end
      S_Q_ACC: begin
        cmd.walk_acc = 1'b1;
        state_nxt    = sts.walk_last ? S_Q_FIN : S_Q_RD;
      end
      S_Q_FIN: begin
        if (sts.cnt_zero) begin
          state_nxt = S_Q_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_Q_DIV;
        end
      end
      S_Q_DIV: begin
        if (sts.div_done) state_nxt = S_Q_EMIT;
      end
      S_Q_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = sts.dim_last ? S_IDLE : S_Q_INIT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: design/bvs_dp.sv
// ----------------------------------------------------------------------------
// bvs_dp
// Bin memories, bin mapping, region walker, accumulators and result register.
// ----------------------------------------------------------------------------
`include "binned_vector_stats_2d_assert.svh"
module bvs_dp #(
  parameter int GRID_W = bvs_pkg::GRID_W_DEF,
  parameter int GRID_H = bvs_pkg::GRID_H_DEF,
  parameter int DIM    = bvs_pkg::DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bvs_pkg::cmd_t                    cmd,
  output bvs_pkg::status_t                 sts,
  input  logic [1:0]                       in_func,
  input  logic signed [bvs_pkg::CW-1:0]    in_coord_x,
  input  logic signed [bvs_pkg::CW-1:0]    in_coord_y,
  input  logic signed [bvs_pkg::CW-1:0]    in_coord_x2,
  input  logic signed [bvs_pkg::CW-1:0]    in_coord_y2,
  input  logic signed [bvs_pkg::CW-1:0]    in_radius,
  input  logic signed [bvs_pkg::VW-1:0]    in_value,
  output logic                             out_valid,
  output logic [5:0]                       out_dim_index,
  output logic [bvs_pkg::NW-1:0]           out_total_count,
  output logic signed [bvs_pkg::SW-1:0]    out_elem_sum,
  output logic signed [bvs_pkg::VW-1:0]    out_elem_min,
  output logic signed [bvs_pkg::VW-1:0]    out_elem_max,
  output logic signed [bvs_pkg::VW-1:0]    out_elem_avg,
  output logic                             out_zero_count,
  output logic                             out_last
);
  import bvs_pkg::*;

  localparam int XW  = $clog2(GRID_W);
  localparam int YW  = $clog2(GRID_H);
  localparam int JW  = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int BW  = XW + YW;
  localparam int AW  = BW + JW;
  localparam int EW  = SW + 2 * VW;
  localparam int XN1 = GRID_W - 1;
  localparam int YN1 = GRID_H - 1;
  localparam int XQ  = 32768 / XN1;
  localparam int XR  = 32768 % XN1;
  localparam int YQ  = 32768 / YN1;
  localparam int YR  = 32768 % YN1;
  localparam logic [JW-1:0] J_LAST = JW'(DIM - 1);

  // Trunc-toward-zero bin index of a Q2.14 coordinate for a grid of nm1+1 bins.
  function automatic logic signed [13:0] bin_of(input logic signed [16:0] c,
                                                input logic [10:0] nm1);
    logic signed [29:0] m;
    logic signed [29:0] n;
    logic signed [29:0] p;
    logic signed [29:0] pa;
    m  = 30'(c) + 30'sd16384;
    n  = $signed({19'd0, nm1});
    p  = m * n;
    pa = p[29] ? p + 30'sd32767 : p;
    return pa[28:15];
  endfunction

  // Saturate a grown sum back to 40 bits.
  function automatic logic signed [SW-1:0] sat_sum(input logic signed [SW:0] a);
    if (a[SW] != a[SW-1]) return a[SW] ? S_MIN : S_MAX;
    return a[SW-1:0];
  endfunction

  // Captured beat.
  logic [1:0]           func_r;
  logic signed [CW-1:0] cx_r, cy_r, cx2_r, cy2_r, rad_r;
  logic signed [VW-1:0] val_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      cx_r   <= in_coord_x;
      cy_r   <= in_coord_y;
      cx2_r  <= in_coord_x2;
      cy2_r  <= in_coord_y2;
      rad_r  <= in_radius;
      val_r  <= in_value;
    end
  end

  // Region bounds from the command.
  logic                 disc;
  logic signed [16:0]   xlo, xhi, ylo, yhi;
  logic signed [13:0]   bxl, bxh, byl, byh;
  logic signed [13:0]   xl_c, xh_c, yl_c, yh_c;
  logic                 pt_in;

  always_comb begin
    disc = (func_r == FUNC_DISC) && !rad_r[CW-1];
    xlo  = 17'(cx_r);
    ylo  = 17'(cy_r);
    xhi  = 17'(cx_r);
    yhi  = 17'(cy_r);
    if (disc) begin
      xlo = 17'(cx_r) - 17'(rad_r);
      ylo = 17'(cy_r) - 17'(rad_r);
      xhi = 17'(cx_r) + 17'(rad_r);
      yhi = 17'(cy_r) + 17'(rad_r);
    end else if (func_r == FUNC_RECT) begin
      xhi = 17'(cx2_r);
      yhi = 17'(cy2_r);
    end
    bxl   = bin_of(xlo, 11'(XN1));
    bxh   = bin_of(xhi, 11'(XN1));
    byl   = bin_of(ylo, 11'(YN1));
    byh   = bin_of(yhi, 11'(YN1));
    xl_c  = bxl[13] ? 14'sd0 : bxl;
    yl_c  = byl[13] ? 14'sd0 : byl;
    xh_c  = (bxh > $signed(14'(XN1))) ? $signed(14'(XN1)) : bxh;
    yh_c  = (byh > $signed(14'(YN1))) ? $signed(14'(YN1)) : byh;
    pt_in = !bxl[13] && (bxl <= $signed(14'(XN1))) &&
            !byl[13] && (byl <= $signed(14'(YN1)));
  end

  logic [XW-1:0] x0_r, x1_r;
  logic [YW-1:0] y0_r, y1_r;
  logic          empty_r;
  logic          disc_r;
  logic [31:0]   r2_r;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      x0_r    <= xl_c[XW-1:0];
      x1_r    <= xh_c[XW-1:0];
      y0_r    <= yl_c[YW-1:0];
      y1_r    <= yh_c[YW-1:0];
      empty_r <= (xl_c > xh_c) || (yl_c > yh_c);
      disc_r  <= disc;
      r2_r    <= 32'(rad_r * rad_r);
    end
  end

  // Add sequence state: element counter and latched bin.
  logic [JW-1:0] ecnt_r;
  logic [BW-1:0] lbin_r;
  logic          lvalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecnt_r   <= '0;
      lbin_r   <= '0;
      lvalid_r <= 1'b0;
    end else if (cmd.clr_step) begin
      ecnt_r   <= '0;
      lvalid_r <= 1'b0;
    end else if (cmd.setup && func_r == FUNC_ADD && ecnt_r == '0) begin
      lvalid_r <= pt_in;
      lbin_r   <= pt_in ? {byl[YW-1:0], bxl[XW-1:0]} : '0;
    end else if (cmd.add_wr) begin
      ecnt_r <= (ecnt_r == J_LAST) ? '0 : ecnt_r + 1'b1;
    end
  end

  // Clearing sweep address; wraps to zero at the end of each pass.
  logic [AW-1:0] clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  // Walker position, bin centres and query element.
  logic [XW-1:0] x_r;
  logic [YW-1:0] y_r;
  logic [JW-1:0] j_r;
  logic [15:0]   cxc_r, cyc_r;
  logic [10:0]   cxr_r, cyr_r;
  logic [15:0]   cx_step, cy_step;
  logic [10:0]   cxr_step, cyr_step, cx_sum, cy_sum;

  // Next bin centre: floor(i * 32768 / (n - 1)) kept as quotient and remainder.
  always_comb begin
    cx_sum = cxr_r + 11'(XR);
    cy_sum = cyr_r + 11'(YR);
    if (cx_sum >= 11'(XN1)) begin
      cx_step  = cxc_r + 16'(XQ) + 16'd1;
      cxr_step = cx_sum - 11'(XN1);
    end else begin
      cx_step  = cxc_r + 16'(XQ);
      cxr_step = cx_sum;
    end
    if (cy_sum >= 11'(YN1)) begin
      cy_step  = cyc_r + 16'(YQ) + 16'd1;
      cyr_step = cy_sum - 11'(YN1);
    end else begin
      cy_step  = cyc_r + 16'(YQ);
      cyr_step = cy_sum;
    end
  end

  // Memories: element word {sum, min, max} and per-bin hit count.
  logic [EW-1:0] emem [2**AW];
  logic [NW-1:0] cmem [2**BW];
  logic [EW-1:0] erd_r;
  logic [NW-1:0] crd_r;
  logic [AW-1:0] raddr;
  logic          rd_en;

  assign rd_en = cmd.add_rd | cmd.walk_rd;
  assign raddr = cmd.add_rd ? {lbin_r, ecnt_r} : {y_r, x_r, j_r};

  always_ff @(posedge clk) begin
    if (rd_en) begin
      erd_r <= emem[raddr];
      crd_r <= cmem[raddr[AW-1:JW]];
    end
  end

  logic signed [SW-1:0] rd_sum;
  logic signed [VW-1:0] rd_min, rd_max;
  logic signed [SW-1:0] add_sum;
  logic signed [VW-1:0] add_min, add_max;
  logic                 ewe, cwe;
  logic [AW-1:0]        waddr;
  logic [EW-1:0]        wdata;
  logic [BW-1:0]        cwaddr;
  logic [NW-1:0]        cwdata;

  assign rd_sum = erd_r[EW-1 -: SW];
  assign rd_min = erd_r[2*VW-1 -: VW];
  assign rd_max = erd_r[VW-1:0];

  // Write port: clearing sweep or add update.
  always_comb begin
    add_sum = sat_sum(41'(rd_sum) + 41'(val_r));
    add_min = (val_r < rd_min) ? val_r : rd_min;
    add_max = (val_r > rd_max) ? val_r : rd_max;
    if (cmd.clr_step) begin
      ewe    = 1'b1;
      waddr  = clr_r;
      wdata  = {{SW{1'b0}}, V_ONE, {VW{1'b0}}};
      cwe    = (clr_r[JW-1:0] == '0);
      cwaddr = clr_r[AW-1:JW];
      cwdata = '0;
    end else begin
      ewe    = cmd.add_wr && lvalid_r;
      waddr  = {lbin_r, ecnt_r};
      wdata  = {add_sum, add_min, add_max};
      cwe    = cmd.add_wr && lvalid_r && (ecnt_r == J_LAST) && (crd_r != '1);
      cwaddr = lbin_r;
      cwdata = crd_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ewe) emem[waddr] <= wdata;
    if (cwe) cmem[cwaddr] <= cwdata;
  end

  // Distance pipeline for the disc test.
  logic signed [17:0] dx_r, dy_r;
  logic [31:0]        dx2_r, dy2_r;
  logic signed [35:0] dx2_full, dy2_full;
  logic               sel;

  assign dx2_full = dx_r * dx_r;
  assign dy2_full = dy_r * dy_r;

  always_ff @(posedge clk) begin
    if (cmd.walk_rd) begin
      dx_r <= $signed({2'b00, cxc_r}) - 18'sd16384 - 18'(cx_r);
      dy_r <= $signed({2'b00, cyc_r}) - 18'sd16384 - 18'(cy_r);
    end
    if (cmd.walk_sq) begin
      dx2_r <= dx2_full[31:0];
      dy2_r <= dy2_full[31:0];
    end
  end

  assign sel = (x_r >= x0_r) && (y_r >= y0_r) &&
               (!disc_r || ({1'b0, dx2_r} + {1'b0, dy2_r} <= {1'b0, r2_r}));

  // Accumulators and walker advance.
  logic [NW-1:0]        cnt_r;
  logic signed [SW-1:0] asum_r;
  logic signed [VW-1:0] amin_r, amax_r;
  logic [NW:0]          cnt_add;

  assign cnt_add = {1'b0, cnt_r} + {1'b0, crd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r <= '0;
    end else if (cmd.setup) begin
      j_r <= '0;
    end else if (cmd.emit) begin
      j_r <= j_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      cnt_r <= '0;
    end else if (cmd.walk_acc && sel && j_r == '0) begin
      cnt_r <= cnt_add[NW] ? '1 : cnt_add[NW-1:0];
    end
    if (cmd.walk_init) begin
      x_r    <= '0;
      y_r    <= '0;
      cxc_r  <= '0;
      cxr_r  <= '0;
      cyc_r  <= '0;
      cyr_r  <= '0;
      asum_r <= '0;
      amin_r <= V_MAX;
      amax_r <= V_MIN;
    end else if (cmd.walk_acc) begin
      if (sel) begin
        asum_r <= sat_sum(41'(asum_r) + 41'(rd_sum));
        if (rd_min < amin_r) amin_r <= rd_min;
        if (rd_max > amax_r) amax_r <= rd_max;
      end
      if (x_r == x1_r) begin
        x_r   <= '0;
        cxc_r <= '0;
        cxr_r <= '0;
        y_r   <= y_r + 1'b1;
        cyc_r <= cy_step;
        cyr_r <= cyr_step;
      end else begin
        x_r   <= x_r + 1'b1;
        cxc_r <= cx_step;
        cxr_r <= cxr_step;
      end
    end
  end

  // Average through the serial divider on magnitudes.
  logic [SW-1:0] div_q;
  logic          div_done;
  logic [SW-1:0] asum_mag;

  assign asum_mag = asum_r[SW-1] ? SW'(-asum_r) : SW'(asum_r);

  bvs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (asum_mag),
    .divisor  (cnt_r),
    .quotient (div_q),
    .done     (div_done)
  );

  logic signed [VW-1:0] avg;

  always_comb begin
    if (cnt_r == '0) begin
      avg = '0;
    end else if (asum_r[SW-1]) begin
      avg = (div_q > SW'(131072)) ? V_MIN : -$signed(div_q[VW-1:0]);
    end else begin
      avg = (div_q > SW'(131071)) ? V_MAX : $signed(div_q[VW-1:0]);
    end
  end

  // Result register, strobed for one cycle per beat.
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_dim_index   <= 6'(j_r);
      out_total_count <= cnt_r;
      out_elem_sum    <= asum_r;
      out_elem_min    <= amin_r;
      out_elem_max    <= amax_r;
      out_elem_avg    <= avg;
      out_zero_count  <= (cnt_r == '0);
      out_last        <= (j_r == J_LAST);
    end
  end

  assign out_valid = out_valid_r;

  // Status back to the sequencer.
  always_comb begin
    sts.func      = func_r;
    sts.clr_done  = (clr_r == '1);
    sts.empty     = empty_r;
    sts.walk_last = (x_r == x1_r) && (y_r == y1_r);
    sts.cnt_zero  = (cnt_r == '0);
    sts.div_done  = div_done;
    sts.dim_last  = (j_r == J_LAST);
  end

  // A result beat is never followed directly by another.
  `BVS_ASSERT(a_emit_single, out_valid |=> !out_valid)
  // An add write always follows its read of the same entry.
  `BVS_ASSERT(a_add_order, cmd.add_wr |-> $past(cmd.add_rd))
  // No result beat right after reset.
  `BVS_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_valid)

endmodule

FILE: tb/binned_vector_stats_2d_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binned_vector_stats_2d_tb
// Self-checking bench for the 2D binned vector statistics block. A local
// histogram model predicts the beats of every rectangle and disc query.
// Directed tests cover clears, add sequences, extreme values and the region
// corner cases. Random traffic of add sequences, queries and clears follows.
// ----------------------------------------------------------------------------
module binned_vector_stats_2d_tb;
  import bvs_pkg::*;

  localparam int NX    = GRID_W_DEF;
  localparam int NY    = GRID_H_DEF;
  localparam int NE    = DIM_DEF;
  localparam int NBIN  = NX * NY;
  localparam int ONE_C = 16384;

  typedef struct {
    logic [5:0]           dim_index;
    logic [NW-1:0]        total_count;
    logic signed [SW-1:0] elem_sum;
    logic signed [VW-1:0] elem_min;
    logic signed [VW-1:0] elem_max;
    logic signed [VW-1:0] elem_avg;
    logic                 zero_count;
    logic                 last;
  } stat_beat_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_func;
  logic signed [CW-1:0] in_coord_x, in_coord_y, in_coord_x2, in_coord_y2, in_radius;
  logic signed [VW-1:0] in_value;
  logic                 out_valid;
  logic [5:0]           out_dim_index;
  logic [NW-1:0]        out_total_count;
  logic signed [SW-1:0] out_elem_sum;
  logic signed [VW-1:0] out_elem_min, out_elem_max, out_elem_avg;
  logic                 out_zero_count, out_last;

  binned_vector_stats_2d u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .in_coord_x2(in_coord_x2), .in_coord_y2(in_coord_y2), .in_radius(in_radius),
    .in_value(in_value), .out_valid(out_valid), .out_dim_index(out_dim_index),
    .out_total_count(out_total_count), .out_elem_sum(out_elem_sum),
    .out_elem_min(out_elem_min), .out_elem_max(out_elem_max),
    .out_elem_avg(out_elem_avg), .out_zero_count(out_zero_count), .out_last(out_last)
  );

  // Clock with a 12 ns period.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Histogram shadow state.
  longint unsigned bin_hits[NBIN];
  longint          bin_sum[NBIN*NE];
  longint          bin_min[NBIN*NE];
  longint          bin_max[NBIN*NE];
  int              elem_pos;
  int              held_bin;
  bit              held_ok;

  // Region accumulators.
  longint unsigned region_hits;
  longint          region_sum[NE];
  longint          region_min[NE];
  longint          region_max[NE];

  stat_beat_t      pending_beats[$];
  int              error_count;
  int              burst_left;
  int              item_count;

  function automatic longint bin_index(longint c, longint n);
    return ((c + ONE_C) * (n - 1)) / 32768;
  endfunction

  function automatic longint clamp_sum(longint a);
    if (a > 64'sd549755813887) return 64'sd549755813887;
    if (a < -64'sd549755813888) return -64'sd549755813888;
    return a;
  endfunction

  task automatic wipe_histogram();
    for (int i = 0; i < NBIN; i++) bin_hits[i] = 0;
    for (int i = 0; i < NBIN * NE; i++) begin
      bin_sum[i] = 0;
      bin_min[i] = 65536;
      bin_max[i] = 0;
    end
    elem_pos = 0;
    held_ok  = 1'b0;
  endtask

  task automatic gather_bin(longint x, longint y);
    int loc;
    loc = int'(y * NX + x);
    region_hits = region_hits + bin_hits[loc];
    if (region_hits > 64'hFFFF_FFFF) region_hits = 64'hFFFF_FFFF;
    for (int j = 0; j < NE; j++) begin
      region_sum[j] = clamp_sum(region_sum[j] + bin_sum[loc*NE+j]);
      if (bin_min[loc*NE+j] < region_min[j]) region_min[j] = bin_min[loc*NE+j];
      if (bin_max[loc*NE+j] > region_max[j]) region_max[j] = bin_max[loc*NE+j];
    end
  endtask

  // Update the shadow state for one accepted command and queue its beats.
  task automatic apply_command(logic [1:0] f, longint cx, longint cy, longint cx2,
                               longint cy2, longint r, longint val);
    longint x, y, x0, x1, y0, y1, dx, dy, avg;
    int k;
    stat_beat_t b;
    if (f == FUNC_CLEAR) begin
      wipe_histogram();
      return;
    end
    if (f == FUNC_ADD) begin
      if (elem_pos == 0) begin
        x = bin_index(cx, NX);
        y = bin_index(cy, NY);
        held_ok  = (x >= 0 && x < NX && y >= 0 && y < NY);
        held_bin = held_ok ? int'(y * NX + x) : 0;
      end
      if (held_ok) begin
        k = held_bin * NE + elem_pos;
        bin_sum[k] = clamp_sum(bin_sum[k] + val);
        if (val < bin_min[k]) bin_min[k] = val;
        if (val > bin_max[k]) bin_max[k] = val;
      end
      if (elem_pos == NE - 1) begin
        if (held_ok && bin_hits[held_bin] != 64'hFFFF_FFFF)
          bin_hits[held_bin]++;
        elem_pos = 0;
      end else begin
        elem_pos++;
      end
      return;
    end
    region_hits = 0;
    for (int j = 0; j < NE; j++) begin
      region_sum[j] = 0;
      region_min[j] = 131071;
      region_max[j] = -131072;
    end
    if (f == FUNC_RECT) begin
      x0 = bin_index(cx, NX);  if (x0 < 0) x0 = 0;
      x1 = bin_index(cx2, NX); if (x1 > NX - 1) x1 = NX - 1;
      y0 = bin_index(cy, NY);  if (y0 < 0) y0 = 0;
      y1 = bin_index(cy2, NY); if (y1 > NY - 1) y1 = NY - 1;
      for (y = y0; y <= y1; y++)
        for (x = x0; x <= x1; x++) gather_bin(x, y);
    end else if (r < 0) begin
      x = bin_index(cx, NX);
      y = bin_index(cy, NY);
      if (x >= 0 && x < NX && y >= 0 && y < NY) gather_bin(x, y);
    end else begin
      x0 = bin_index(cx - r, NX); if (x0 < 0) x0 = 0;
      x1 = bin_index(cx + r, NX); if (x1 > NX - 1) x1 = NX - 1;
      y0 = bin_index(cy - r, NY); if (y0 < 0) y0 = 0;
      y1 = bin_index(cy + r, NY); if (y1 > NY - 1) y1 = NY - 1;
      for (y = y0; y <= y1; y++) begin
        dy = (y * 32768) / (NY - 1) - ONE_C - cy;
        for (x = x0; x <= x1; x++) begin
          dx = (x * 32768) / (NX - 1) - ONE_C - cx;
          if (dx * dx + dy * dy <= r * r) gather_bin(x, y);
        end
      end
    end
    // One beat per vector element.
    for (int j = 0; j < NE; j++) begin
      avg = 0;
      if (region_hits != 0) begin
        avg = region_sum[j] / longint'(region_hits);
        if (avg > 131071) avg = 131071;
        if (avg < -131072) avg = -131072;
      end
      b.dim_index   = j[5:0];
      b.total_count = region_hits[31:0];
      b.elem_sum    = region_sum[j][39:0];
      b.elem_min    = region_min[j][17:0];
      b.elem_max    = region_max[j][17:0];
      b.elem_avg    = avg[17:0];
      b.zero_count  = (region_hits == 0);
      b.last        = (j == NE - 1);
      pending_beats.insert(pending_beats.size(), b);
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Compare every result beat with the oldest expectation.
  always @(posedge clk) begin
    stat_beat_t e;
    if (rst_n && out_valid) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("unexpected beat, dim_index", out_dim_index, -1);
      end else begin
        e = pending_beats.pop_front();
        if (out_dim_index !== e.dim_index)
          report_mismatch("dim_index", out_dim_index, e.dim_index);
        if (out_total_count !== e.total_count)
          report_mismatch("total_count", out_total_count, e.total_count);
        if (out_elem_sum !== e.elem_sum)
          report_mismatch("elem_sum", out_elem_sum, e.elem_sum);
        if (out_elem_min !== e.elem_min)
          report_mismatch("elem_min", out_elem_min, e.elem_min);
        if (out_elem_max !== e.elem_max)
          report_mismatch("elem_max", out_elem_max, e.elem_max);
        if (out_elem_avg !== e.elem_avg)
          report_mismatch("elem_avg", out_elem_avg, e.elem_avg);
        if (out_zero_count !== e.zero_count)
          report_mismatch("zero_count", out_zero_count, e.zero_count);
        if (out_last !== e.last)
          report_mismatch("last", out_last, e.last);
      end
    end
  end

  // Drive one command beat; bursts of random length with random gaps.
  task automatic send_command(logic [1:0] f, int cx, int cy, int cx2, int cy2,
                              int r, int val);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        start = 1'b0;
        repeat (gap - 1) @(negedge clk);
        @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_func     = f;
    in_coord_x  = cx[15:0];
    in_coord_y  = cy[15:0];
    in_coord_x2 = cx2[15:0];
    in_coord_y2 = cy2[15:0];
    in_radius   = r[15:0];
    in_value    = val[17:0];
    start       = 1'b1;
    do @(posedge clk); while (busy);
    apply_command(f, longint'(in_coord_x), longint'(in_coord_y), longint'(in_coord_x2),
                  longint'(in_coord_y2), longint'(in_radius), longint'(in_value));
    burst_left--;
    item_count++;
  endtask

  function automatic int any_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int grid_coord();
    return int'($urandom_range(0, 32767)) - ONE_C;
  endfunction

  function automatic int any_value();
    return int'($urandom_range(0, 262143)) - 131072;
  endfunction

  // Coordinate near the low corner, so the bin walk stays short.
  function automatic int low_coord();
    return int'($urandom_range(0, 9000)) - ONE_C;
  endfunction

  task automatic add_vector(int cx, int cy, int n);
    for (int j = 0; j < n; j++)
      send_command(FUNC_ADD, (j == 0) ? cx : any_coord(), (j == 0) ? cy : any_coord(),
                   any_coord(), any_coord(), any_coord(), any_value());
  endtask

  task automatic test_reset_contents();
    send_command(FUNC_RECT, -ONE_C, -ONE_C, -ONE_C + 3000, -ONE_C + 3000, 0, 0);
  endtask

  task automatic test_add_extremes();
    // Extreme values into the corner bin, then the opposite corner.
    for (int j = 0; j < NE; j++)
      send_command(FUNC_ADD, -ONE_C, -ONE_C, 0, 0, 0, (j % 2) ? 131071 : -131072);
    for (int j = 0; j < NE; j++)
      send_command(FUNC_ADD, ONE_C, ONE_C, 0, 0, 0, (j % 2) ? -131072 : 131071);
    send_command(FUNC_DISC, -ONE_C, -ONE_C, 0, 0, -1, 0);
  endtask

  task automatic test_outside_points();
    // Far outside is dropped; just below -1.0 still lands in bin 0.
    add_vector(32767, 0, NE);
    add_vector(-32768, -32768, NE);
    add_vector(-16400, -16400, NE);
    send_command(FUNC_DISC, -16400, -16400, 0, 0, -32768, 0);
  endtask

  task automatic test_rect_queries();
    send_command(FUNC_RECT, -32768, -32768, 32767, 32767, 0, 0);
    send_command(FUNC_RECT, 8000, 8000, -8000, -8000, 0, 0);
  endtask

  task automatic test_disc_queries();
    send_command(FUNC_DISC, -ONE_C, -ONE_C, 0, 0, 0, 0);
    send_command(FUNC_DISC, 32767, 32767, 0, 0, -1, 0);
    send_command(FUNC_DISC, -ONE_C + 100, -ONE_C + 100, 0, 0, 2000, 0);
    send_command(FUNC_DISC, -32768, -32768, 0, 0, 32767, 0);
  endtask

  task automatic test_partial_add_and_clear();
    // A query in the middle of an add sees the elements so far.
    add_vector(-ONE_C + 600, -ONE_C, 3);
    send_command(FUNC_RECT, -ONE_C, -ONE_C, -ONE_C + 1500, -ONE_C + 1500, 0, 0);
    add_vector(0, 0, NE - 3);
    send_command(FUNC_DISC, -ONE_C + 600, -ONE_C, 0, 0, -5, 0);
    // A clear abandons a partial add.
    add_vector(-ONE_C, -ONE_C, 2);
    send_command(FUNC_CLEAR, any_coord(), any_coord(), any_coord(), any_coord(),
                 any_coord(), any_value());
    add_vector(-ONE_C + 1200, -ONE_C + 600, NE);
    send_command(FUNC_RECT, -ONE_C, -ONE_C, -ONE_C + 2000, -ONE_C + 2000, 0, 0);
  endtask

  task automatic test_random_traffic();
    int pick;
    int stop_at;
    stop_at = item_count + 50;
    while (item_count < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 50)
        add_vector(low_coord(), low_coord(), NE);
      else if (pick < 55)
        add_vector(($urandom_range(0, 3) == 0) ? any_coord() : grid_coord(),
                   grid_coord(), NE);
      else if (pick < 62)
        add_vector(low_coord(), low_coord(), $urandom_range(1, NE - 1));
      else if (pick < 77)
        send_command(FUNC_RECT, any_coord(), any_coord(), low_coord(), low_coord(),
                     any_coord(), any_value());
      else if (pick < 90)
        send_command(FUNC_DISC, low_coord(), low_coord(), any_coord(), any_coord(),
                     ($urandom_range(0, 3) == 0) ? -int'($urandom_range(1, 32768))
                                                 : int'($urandom_range(0, 4000)),
                     any_value());
      else if (pick < 96)
        send_command($urandom_range(0, 1) ? FUNC_RECT : FUNC_DISC, any_coord(),
                     any_coord(), any_coord(), any_coord(), any_coord(), any_value());
      else
        send_command(FUNC_CLEAR, any_coord(), any_coord(), any_coord(), any_coord(),
                     any_coord(), any_value());
    end
  endtask

  // Main sequence.
  initial begin
    int guard;
    error_count = 0;
    burst_left  = 0;
    item_count  = 0;
    start       = 1'b0;
    in_func     = FUNC_CLEAR;
    in_coord_x  = '0;
    in_coord_y  = '0;
    in_coord_x2 = '0;
    in_coord_y2 = '0;
    in_radius   = '0;
    in_value    = '0;
    rst_n       = 1'b0;
    wipe_histogram();
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_reset_contents();
    test_add_extremes();
    test_outside_points();
    test_rect_queries();
    test_disc_queries();
    test_partial_add_and_clear();
    test_random_traffic();

    @(negedge clk);
    start = 1'b0;
    // Drain the results, then let the block settle.
    guard = 0;
    while ((pending_beats.size() != 0 || busy) && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (50) @(negedge clk);
    if (error_count == 0 && pending_beats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #200_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
